FILE: src/pwm_input_capture_measure_defines.svh
// Assertion macros shared by the PWM capture measurement RTL.
`ifndef PWM_INPUT_CAPTURE_MEASURE_DEFINES_SVH
`define PWM_INPUT_CAPTURE_MEASURE_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(name, clk, rst_n, pre, post)

`define ASSERT_NEXT(name, clk, rst_n, pre, post)

`endif

`endif

FILE: src/pimc_pkg.sv
// Types and constants of the PWM capture measurement block.
`timescale 1ns / 1ps

package pimc_pkg;

    localparam int TICK_W     = 7;
    localparam int READY_W    = 8;
    localparam int PERIOD_W   = 30;
    localparam int DUTY_W     = 7;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int STEP_W     = $clog2(TICK_W);

    // One result item: measurement_valid travels in tuser, the rest in tdata.
    localparam int OUT_BITS   = PERIOD_W + DUTY_W + 1 + COUNT_W + 1 + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_US     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_AFTER = 1'd1;

    localparam logic [TICK_W-1:0]  TICK_RESET  = 7'd4;
    localparam logic [READY_W-1:0] READY_RESET = 8'd5;

    localparam logic CMD_CAPTURE  = 1'b0;
    localparam logic CMD_OVERFLOW = 1'b1;

    localparam logic [1:0] EDGE_FIRST  = 2'd0;
    localparam logic [1:0] EDGE_SECOND = 2'd1;
    localparam logic [1:0] EDGE_FALL   = 2'd2;

    localparam logic [DUTY_W-1:0]  DUTY_FULL = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(TICK_W - 1);

    // Operations of the shared add/subtract unit.
    localparam logic [2:0] OP_IDLE   = 3'd0;
    localparam logic [2:0] OP_PER    = 3'd1;
    localparam logic [2:0] OP_ON     = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_CMP    = 3'd4;
    localparam logic [2:0] OP_SCALE1 = 3'd5;
    localparam logic [2:0] OP_SCALE2 = 3'd6;
    localparam logic [2:0] OP_DIV    = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [STEP_W-1:0] bit_idx;
    } pimc_ctl_t;

endpackage

FILE: src/pwm_input_capture_measure.sv
// PWM period and duty measurement from timer capture and overflow events.
// Overflow and rising-edge items go straight to S_DONE; a falling edge first has the
// shared add/subtract unit run two differences, 7 shift-add steps, a compare, two
// scale steps and 7 divide steps. S_DONE registers the result once the output is free.
// One item at a time: s_tready is low until then; a stalled result holds the input.
// Reset clears the control and edge tracking state; tick_us returns to 4, ready_after to 5.
`timescale 1ns / 1ps

`include "pwm_input_capture_measure_defines.svh"

module pwm_input_capture_measure
    import pimc_pkg::*;
#(
    parameter int CAPTURE_BITS  = 16,
    parameter int OVERFLOW_BITS = 8,
    localparam int IN_DATA_W    = ((CAPTURE_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // capture_value
    input  logic [0:0]            s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // period_us, duty_percent, zero_period, measurements_done, ready_res,
    // capture_falling_next
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]            m_tuser,   // measurement_valid
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SW = CAPTURE_BITS + OVERFLOW_BITS;

    logic [TICK_W-1:0]        tick_reg;
    logic [READY_W-1:0]       ready_after_reg;
    logic [1:0]               edge_reg;
    logic [OVERFLOW_BITS-1:0] ovf_reg;
    logic [SW-1:0]            first_reg;
    logic [SW-1:0]            second_reg;
    logic [SW-1:0]            fall_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     meas_reg;

    logic                     m_tvalid_reg;
    logic                     out_valid_reg;
    logic [PERIOD_W-1:0]      out_period_reg;
    logic [DUTY_W-1:0]        out_duty_reg;
    logic                     out_zero_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_ready_reg;
    logic                     out_falling_reg;

    logic                     accept;
    logic                     is_fall;
    logic [SW-1:0]            stamp;
    logic                     busy;
    logic                     done;
    logic                     out_free;
    pimc_ctl_t                ctl;
    logic [PERIOD_W-1:0]      dp_period;
    logic [DUTY_W-1:0]        dp_duty;
    logic                     dp_zero;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy;
    assign is_fall  = (s_tuser[0] == CMD_CAPTURE) && (edge_reg == EDGE_FALL);
    assign stamp    = {ovf_reg, s_tdata[CAPTURE_BITS-1:0]};
    assign out_free = !m_tvalid_reg || m_tready;

    pimc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .meas     (is_fall),
        .out_free (out_free),
        .ctl      (ctl),
        .busy     (busy),
        .done     (done)
    );

    pimc_dp #(
        .STAMP_BITS(SW)
    ) u_dp (
        .clk          (clk),
        .ctl          (ctl),
        .tick_us      (tick_reg),
        .first_stamp  (first_reg),
        .second_stamp (second_reg),
        .fall_stamp   (fall_reg),
        .period_us    (dp_period),
        .duty_percent (dp_duty),
        .zero_period  (dp_zero)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= TICK_RESET;
            ready_after_reg <= READY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TICK_US:     tick_reg        <= cfg_wdata[TICK_W-1:0];
                CFG_READY_AFTER: ready_after_reg <= cfg_wdata[READY_W-1:0];
            endcase
        end
    end

    // Edge tracking and timestamp state, updated at the input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg   <= EDGE_FIRST;
            ovf_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= '0;
            meas_reg   <= 1'b0;
        end
        else if (accept)
        begin
            meas_reg <= is_fall;
            if (s_tuser[0] == CMD_OVERFLOW)
            begin
                ovf_reg <= ovf_reg + 1'b1;
            end
            else
            begin
                unique case (edge_reg)
                    EDGE_SECOND:
                    begin
                        second_reg <= stamp;
                        edge_reg   <= EDGE_FALL;
                    end
                    EDGE_FALL:
                    begin
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        ovf_reg  <= '0;
                        edge_reg <= EDGE_FIRST;
                    end
                    default:
                    begin
                        first_reg <= stamp;
                        edge_reg  <= EDGE_SECOND;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_fall)
        begin
            fall_reg <= stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_valid_reg   <= meas_reg;
            out_period_reg  <= meas_reg ? dp_period : '0;
            out_duty_reg    <= meas_reg ? dp_duty : '0;
            out_zero_reg    <= meas_reg && dp_zero;
            out_count_reg   <= count_reg;
            out_ready_reg   <= (count_reg >= ready_after_reg);
            out_falling_reg <= (edge_reg == EDGE_FALL);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_falling_reg, out_ready_reg, out_count_reg,
                                   out_zero_reg, out_duty_reg, out_period_reg});

    `ASSERT_IMPLIES(a_no_meas_zero, clk, rst_n, m_tvalid && !m_tuser[0],
                    out_period_reg == '0 && out_duty_reg == '0 && !out_zero_reg)

    `ASSERT_IMPLIES(a_duty_range, clk, rst_n, m_tvalid,
                    out_duty_reg <= DUTY_FULL && (!out_zero_reg || out_duty_reg == '0))

    `ASSERT_NEXT(a_fall_clears, clk, rst_n, accept && is_fall,
                 edge_reg == EDGE_FIRST && ovf_reg == '0 && busy)

endmodule

FILE: src/pimc_alu.sv
// Shared add/subtract unit with carry out.
`timescale 1ns / 1ps

module pimc_alu #(
    parameter int W = 31
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic [W-1:0] b_eff;
    logic [W:0]   total;

    assign b_eff = sub ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, sub};
    assign sum   = total[W-1:0];
    // On a subtract, carry set means a >= b.
    assign carry = total[W];

endmodule

FILE: src/pimc_seq.sv
// Sequencer that steps the shared unit through one measurement.
`timescale 1ns / 1ps

module pimc_seq
    import pimc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      meas,
    input  logic      out_free,
    output pimc_ctl_t ctl,
    output logic      busy,
    output logic      done
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PER    = 4'd1;
    localparam logic [3:0] S_ON     = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_CMP    = 4'd4;
    localparam logic [3:0] S_SCALE1 = 4'd5;
    localparam logic [3:0] S_SCALE2 = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = meas ? S_PER : S_DONE;
                end
            end
            S_PER:    state_next = S_ON;
            S_ON:
            begin
                state_next = S_MUL;
                cnt_next   = STEP_LAST;
            end
            S_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_CMP:    state_next = S_SCALE1;
            S_SCALE1: state_next = S_SCALE2;
            S_SCALE2:
            begin
                state_next = S_DIV;
                cnt_next   = STEP_LAST;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        ctl.bit_idx = cnt_reg;
        unique case (state_reg)
            S_PER:    ctl.op = OP_PER;
            S_ON:     ctl.op = OP_ON;
            S_MUL:    ctl.op = OP_MUL;
            S_CMP:    ctl.op = OP_CMP;
            S_SCALE1: ctl.op = OP_SCALE1;
            S_SCALE2: ctl.op = OP_SCALE2;
            S_DIV:    ctl.op = OP_DIV;
            default:  ctl.op = OP_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE) && out_free;

endmodule

FILE: src/pimc_dp.sv
// Measurement datapath: tick differences, period product and duty division.
`timescale 1ns / 1ps

module pimc_dp
    import pimc_pkg::*;
#(
    parameter int STAMP_BITS = 24
) (
    input  logic                  clk,
    input  pimc_ctl_t             ctl,
    input  logic [TICK_W-1:0]     tick_us,
    input  logic [STAMP_BITS-1:0] first_stamp,
    input  logic [STAMP_BITS-1:0] second_stamp,
    input  logic [STAMP_BITS-1:0] fall_stamp,
    output logic [PERIOD_W-1:0]   period_us,
    output logic [DUTY_W-1:0]     duty_percent,
    output logic                  zero_period
);

    localparam int SW = STAMP_BITS;
    localparam int PW = SW + TICK_W;
    localparam int XW = PW + PERIOD_W;

    logic [SW-1:0]     per_reg;
    logic [SW-1:0]     on_reg;
    logic [PW-1:0]     acc_reg;
    logic [PW-1:0]     num_reg;
    logic [DUTY_W-1:0] q_reg;
    logic              sat_reg;

    logic [PW-1:0] alu_a;
    logic [PW-1:0] alu_b;
    logic          alu_sub;
    logic [PW-1:0] alu_sum;
    logic          alu_carry;
    logic [XW-1:0] prod_x;

    pimc_alu #(
        .W(PW)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_comb
    begin
        unique case (ctl.op)
            OP_PER:
            begin
                alu_a   = PW'(second_stamp);
                alu_b   = PW'(first_stamp);
                alu_sub = 1'b1;
            end
            OP_ON:
            begin
                alu_a   = PW'(fall_stamp);
                alu_b   = PW'(second_stamp);
                alu_sub = 1'b1;
            end
            OP_MUL:
            begin
                // Shift-add over tick_us, most significant bit first.
                alu_a   = {acc_reg[PW-2:0], 1'b0};
                alu_b   = tick_us[ctl.bit_idx] ? PW'(per_reg) : '0;
                alu_sub = 1'b0;
            end
            OP_CMP:
            begin
                alu_a   = PW'(on_reg);
                alu_b   = PW'(per_reg);
                alu_sub = 1'b1;
            end
            OP_SCALE1:
            begin
                // On time times 100 is built as 64x + 32x + 4x.
                alu_a   = PW'(on_reg) << 6;
                alu_b   = PW'(on_reg) << 5;
                alu_sub = 1'b0;
            end
            OP_SCALE2:
            begin
                alu_a   = num_reg;
                alu_b   = PW'(on_reg) << 2;
                alu_sub = 1'b0;
            end
            OP_DIV:
            begin
                alu_a   = num_reg;
                alu_b   = PW'(per_reg) << ctl.bit_idx;
                alu_sub = 1'b1;
            end
            OP_IDLE:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_PER:    per_reg <= alu_sum[SW-1:0];
            OP_ON:
            begin
                on_reg  <= alu_sum[SW-1:0];
                acc_reg <= '0;
            end
            OP_MUL:    acc_reg <= alu_sum;
            // The duty ratio is independent of tick_us, and an on time of at
            // least the period saturates it, which keeps the quotient in 7 bits.
            OP_CMP:    sat_reg <= alu_carry;
            OP_SCALE1: num_reg <= alu_sum;
            OP_SCALE2:
            begin
                num_reg <= alu_sum;
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                if (alu_carry)
                begin
                    num_reg            <= alu_sum;
                    q_reg[ctl.bit_idx] <= 1'b1;
                end
            end
            OP_IDLE:
            begin
            end
        endcase
    end

    assign prod_x       = XW'(acc_reg);
    assign zero_period  = (acc_reg == '0);
    assign period_us    = (|prod_x[XW-1:PERIOD_W]) ? '1 : prod_x[PERIOD_W-1:0];
    assign duty_percent = zero_period ? '0 : (sat_reg ? DUTY_FULL : q_reg);

endmodule
